// File: rtl/imq_pkg.sv
// ----------------------------------------------------------------------------
// imq_pkg
// Shared types and constants of the indexed max-priority queue core.
// ----------------------------------------------------------------------------
package imq_pkg;

  localparam int unsigned ID_W  = 10;
  localparam int unsigned AMT_W = 16;
  localparam int unsigned SEQ_W = 32;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_INCREASE = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_PUBLISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic ins_wr;
    logic rem_wr;
    logic inc_rd;
    logic inc_wr;
    logic op_load;
    logic scan_start;
    logic scan_rd;
    logic res_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic id_ok;
    logic idx_last;
  } status_t;

endpackage

// File: rtl/imq_if.sv
// ----------------------------------------------------------------------------
// imq_req_if / imq_rsp_if
// Valid/ready channels for requests into and results out of the queue core.
// ----------------------------------------------------------------------------
interface imq_req_if;
  import imq_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [ID_W-1:0]   entry_id;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, output mode, output entry_id, output amount, input ready);
  modport sink   (input valid, input mode, input entry_id, input amount, output ready);
endinterface

interface imq_rsp_if;
  import imq_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] best_id;
  logic            is_empty;

  modport source (output valid, output best_id, output is_empty, input ready);
  modport sink   (input valid, input best_id, input is_empty, output ready);
endinterface

// File: rtl/imq_ctrl.sv
// ----------------------------------------------------------------------------
// imq_ctrl
// Sequencer: clearing pass, request dispatch, table scan and result hand-off.
// ----------------------------------------------------------------------------
module imq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       mode_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  imq_pkg::status_t status_i,
  output imq_pkg::cmd_t    cmd_o
);
  import imq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_vld_q, out_vld_d;
  mode_e       mode;
  logic        slot_free;

  assign mode      = mode_e'(mode_i);
  assign slot_free = !out_vld_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.idx_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mode == MODE_QUERY) begin
            state_d = ST_SCAN;
          end else if (mode == MODE_INCREASE && status_i.id_ok) begin
            state_d = ST_INC_WR;
          end
        end
      end
      ST_INC_WR:  state_d = ST_IDLE;
      ST_SCAN: begin
        if (status_i.idx_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:   state_d = ST_PUBLISH;
      ST_PUBLISH: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.op_load = in_valid_i;
        if (in_valid_i) begin
          case (mode)
            MODE_INSERT:   cmd_o.ins_wr     = status_i.id_ok;
            MODE_INCREASE: cmd_o.inc_rd     = status_i.id_ok;
            MODE_REMOVE:   cmd_o.rem_wr     = status_i.id_ok;
            MODE_QUERY:    cmd_o.scan_start = 1'b1;
            default:       cmd_o.op_load    = 1'b0;
          endcase
        end
      end
      ST_INC_WR:  cmd_o.inc_wr   = 1'b1;
      ST_SCAN:    cmd_o.scan_rd  = 1'b1;
      ST_PUBLISH: cmd_o.res_load = slot_free;
      default:    cmd_o = '0;
    endcase
  end

  // Output register valid: set on load, drop once the beat is taken.
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.res_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// File: rtl/imq_datapath.sv
// ----------------------------------------------------------------------------
// imq_datapath
// Entry memory, sequence counter, scan compare and result register.
// ----------------------------------------------------------------------------
module imq_datapath #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned PRIO_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [imq_pkg::ID_W-1:0]  entry_id_i,
  input  logic [imq_pkg::AMT_W-1:0] amount_i,
  input  imq_pkg::cmd_t            cmd_i,
  output imq_pkg::status_t         status_o,
  output logic [imq_pkg::ID_W-1:0]  best_id_o,
  output logic                     is_empty_o
);
  import imq_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned SUM_W = ((PRIO_BITS > AMT_W) ? PRIO_BITS : AMT_W) + 1;
  localparam logic [SUM_W-1:0] PRIO_TOP = SUM_W'({PRIO_BITS{1'b1}});

  typedef struct packed {
    logic                 present;
    logic [PRIO_BITS-1:0] prio;
    logic [SEQ_W-1:0]     seq;
  } entry_t;

  entry_t mem_q [MAX_ENTRIES];
  entry_t rd_q;

  logic [IDX_W-1:0]     in_idx;
  logic [IDX_W-1:0]     id_q;
  logic [AMT_W-1:0]     amt_q;
  logic [SEQ_W-1:0]     next_seq_q;
  logic [IDX_W-1:0]     scan_idx_q;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 found_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [PRIO_BITS-1:0] best_prio_q;
  logic [SEQ_W-1:0]     best_seq_q;
  logic [ID_W-1:0]      res_id_q;
  logic                 res_empty_q;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [SUM_W-1:0]     ins_ext;
  logic [SUM_W-1:0]     inc_sum;
  logic [PRIO_BITS-1:0] ins_prio;
  logic [PRIO_BITS-1:0] inc_prio;
  logic                 better;

  assign in_idx = IDX_W'(entry_id_i);

  assign status_o.id_ok    = 32'(entry_id_i) < 32'(MAX_ENTRIES);
  assign status_o.idx_last = scan_idx_q == IDX_W'(MAX_ENTRIES - 1);

  // Saturate insert priority and the increase sum at the top priority.
  assign ins_ext  = SUM_W'(amount_i);
  assign inc_sum  = SUM_W'(rd_q.prio) + SUM_W'(amt_q);
  assign ins_prio = PRIO_BITS'((ins_ext > PRIO_TOP) ? PRIO_TOP : ins_ext);
  assign inc_prio = PRIO_BITS'((inc_sum > PRIO_TOP) ? PRIO_TOP : inc_sum);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = id_q;
    wr_data = '0;
    if (cmd_i.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = scan_idx_q;
    end else if (cmd_i.ins_wr) begin
      wr_en   = 1'b1;
      wr_addr = in_idx;
      wr_data = '{present: 1'b1, prio: ins_prio, seq: next_seq_q};
    end else if (cmd_i.rem_wr) begin
      wr_en   = 1'b1;
      wr_addr = in_idx;
    end else if (cmd_i.inc_wr && rd_q.present) begin
      wr_en   = 1'b1;
      wr_data = '{present: 1'b1, prio: inc_prio, seq: rd_q.seq};
    end
  end

  assign rd_en   = cmd_i.inc_rd || cmd_i.scan_rd;
  assign rd_addr = cmd_i.scan_rd ? scan_idx_q : in_idx;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // Strictly better replaces: ties in priority and sequence keep the lower id.
  assign better = rd_q.present &&
                  (!found_q || (rd_q.prio > best_prio_q) ||
                   ((rd_q.prio == best_prio_q) && (rd_q.seq < best_seq_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q <= '0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.ins_wr) next_seq_q <= next_seq_q + 1'b1;
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_rd || cmd_i.clr_wr) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        found_q <= 1'b0;
      end else if (cmp_vld_q && better) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_load) begin
      id_q  <= in_idx;
      amt_q <= amount_i;
    end
    cmp_idx_q <= scan_idx_q;
    if (cmp_vld_q && better) begin
      best_idx_q  <= cmp_idx_q;
      best_prio_q <= rd_q.prio;
      best_seq_q  <= rd_q.seq;
    end
    if (cmd_i.res_load) begin
      res_id_q    <= found_q ? ID_W'(best_idx_q) : '0;
      res_empty_q <= !found_q;
    end
  end

  assign best_id_o  = res_id_q;
  assign is_empty_o = res_empty_q;

endmodule

// File: rtl/indexed_max_priority_queue_core.sv
// ----------------------------------------------------------------------------
// indexed_max_priority_queue_core
// Keyed max-priority table: insert, increase, remove and query-highest.
// ----------------------------------------------------------------------------
//
//  Port    Dir   Beat carries                  Notes
//  req_i   in    mode, entry_id, amount        one operation per beat
//  rsp_o   out   best_id, is_empty             one beat per query, none else
//
//  Insert and remove are a single write, increase a read, then a write back.
//  A query reads the entry memory one entry per cycle over the whole table,
//  then compares and loads the result register.
//  After reset a clearing pass zeroes the memory; req_i is held not ready
//  during it.
//  A finished result waits in the output register while new requests are
//  taken; a query that completes while that beat is still untaken holds.
// ----------------------------------------------------------------------------
module indexed_max_priority_queue_core #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned PRIO_BITS   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  imq_req_if.sink   req_i,
  imq_rsp_if.source rsp_o
);
  import imq_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: owns request ready and the result valid.
  imq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .mode_i      (req_i.mode),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: entry memory, scan compare and result payload.
  imq_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .PRIO_BITS   (PRIO_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_id_i (req_i.entry_id),
    .amount_i   (req_i.amount),
    .cmd_i      (cmd),
    .status_o   (status),
    .best_id_o  (rsp_o.best_id),
    .is_empty_o (rsp_o.is_empty)
  );

endmodule

// File: tb/indexed_max_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_max_priority_queue_core_tb
// Self-checking bench for the keyed max-priority table. A shadow table in the
// bench follows every accepted request beat and predicts each query result.
// A checker compares every result beat against the oldest prediction. The run
// goes through directed corner cases, then random traffic over small and wide
// id pools with random idling on both channels and one stall-free stretch.
// ----------------------------------------------------------------------------
module indexed_max_priority_queue_core_tb;
  import imq_pkg::*;

  localparam int unsigned TB_ENTRIES   = 1024;
  localparam int unsigned TB_PRIO_BITS = 16;
  localparam longint unsigned PRIO_TOP = (64'd1 << TB_PRIO_BITS) - 1;
  // One query scans the whole table, plus compare and result load.
  localparam int unsigned QUERY_LAT    = TB_ENTRIES + 3;
  localparam int unsigned DRAIN_LIMIT  = 64 * QUERY_LAT;
  localparam int unsigned IDLE_PCT     = 32;

  typedef struct packed {
    logic [ID_W-1:0] best_id;
    logic            is_empty;
  } best_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rsp_ready_q = 1'b0;
  bit   stall_en;

  imq_req_if req_if ();
  imq_rsp_if rsp_if ();

  assign rsp_if.ready = rsp_ready_q;

  indexed_max_priority_queue_core #(
    .MAX_ENTRIES(TB_ENTRIES),
    .PRIO_BITS  (TB_PRIO_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow table: the bench's own copy of the entry state.
  // --------------------------------------------------------------------------
  bit                    shadow_present [TB_ENTRIES];
  logic [31:0]           shadow_prio    [TB_ENTRIES];
  logic [SEQ_W-1:0]      shadow_seq     [TB_ENTRIES];
  logic [SEQ_W-1:0]      shadow_next_seq;
  logic [10:0]           shadow_live;

  best_result_t          expected_best_q [$];

  int unsigned reqs_sent;
  int unsigned queries_sent;
  int unsigned results_checked;
  int unsigned err_count;

  // Apply one accepted request beat to the shadow table; queue the predicted
  // result of a query.
  function automatic void apply_table_op(mode_e m, logic [ID_W-1:0] id,
                                         logic [AMT_W-1:0] amt);
    bit               found;
    int unsigned      best;
    longint unsigned  sum;
    best_result_t     res;
    found = 1'b0;
    best  = 0;
    if (m == MODE_QUERY) begin
      // Scan upward so that a full tie (priority and arrival) keeps the
      // lower id.
      for (int unsigned i = 0; i < TB_ENTRIES; i++) begin
        if (shadow_present[i]) begin
          if (!found || shadow_prio[i] > shadow_prio[best] ||
              (shadow_prio[i] == shadow_prio[best] &&
               shadow_seq[i] < shadow_seq[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      res.best_id  = found ? best[ID_W-1:0] : '0;
      res.is_empty = !found;
      expected_best_q.push_back(res);
      return;
    end
    // Ids past the table are dropped by every other operation.
    if (id >= TB_ENTRIES) return;
    case (m)
      MODE_INSERT: begin
        if (!shadow_present[id]) begin
          shadow_present[id] = 1'b1;
          shadow_live        = shadow_live + 11'd1;
        end
        shadow_prio[id] = (amt > PRIO_TOP) ? PRIO_TOP[31:0] : 32'(amt);
        shadow_seq[id]  = shadow_next_seq;
        shadow_next_seq = shadow_next_seq + 1;
      end
      MODE_INCREASE: begin
        // Saturate the sum; keep the arrival stamp.
        if (shadow_present[id]) begin
          sum = longint'(shadow_prio[id]) + amt;
          shadow_prio[id] = (sum > PRIO_TOP) ? PRIO_TOP[31:0] : sum[31:0];
        end
      end
      default: begin
        if (shadow_present[id]) begin
          shadow_present[id] = 1'b0;
          shadow_live        = shadow_live - 11'd1;
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result beat with the oldest
  // prediction, then pick the ready level for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : rsp_check
    best_result_t exp_r;
    if (rst_ni === 1'b1 && rsp_if.valid && rsp_if.ready) begin
      if (expected_best_q.size() == 0) begin
        $display("%0t ERROR result beat with nothing expected: best_id=%0d is_empty=%0b",
                 $time, rsp_if.best_id, rsp_if.is_empty);
        err_count++;
      end else begin
        exp_r = expected_best_q.pop_front();
        results_checked++;
        if (rsp_if.is_empty !== exp_r.is_empty) begin
          $display("%0t ERROR is_empty expected %0b actual %0b",
                   $time, exp_r.is_empty, rsp_if.is_empty);
          err_count++;
        end
        if (rsp_if.best_id !== exp_r.best_id) begin
          $display("%0t ERROR best_id expected %0d actual %0d",
                   $time, exp_r.best_id, rsp_if.best_id);
          err_count++;
        end
      end
    end
    // Stall the result channel at random unless idling is switched off.
    rsp_ready_q <= !(stall_en && $urandom_range(99) < IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Request driver: optional idle gap, then hold the beat until accepted.
  // Returns at the accepting edge with valid still high, so a following beat
  // can go out back to back.
  // --------------------------------------------------------------------------
  task automatic send_req(input mode_e m, input logic [ID_W-1:0] id,
                          input logic [AMT_W-1:0] amt);
    while (stall_en && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= m;
    req_if.entry_id <= id;
    req_if.amount   <= amt;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    apply_table_op(m, id, amt);
    reqs_sent++;
    if (m == MODE_QUERY) queries_sent++;
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    while (expected_best_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Random field pickers.
  // --------------------------------------------------------------------------
  function automatic mode_e pick_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35)      return MODE_INSERT;
    else if (r < 60) return MODE_INCREASE;
    else if (r < 78) return MODE_REMOVE;
    else             return MODE_QUERY;
  endfunction

  // Mostly ids from a small pool so that increases and removes hit present
  // entries; the mask moves the pool across the whole id range.
  function automatic logic [ID_W-1:0] pick_id(int unsigned pool, logic [ID_W-1:0] mask);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85)      return ID_W'($urandom_range(pool - 1)) ^ mask;
    else if (r < 95) return ID_W'($urandom());
    else             return (r[0]) ? '1 : '0;
  endfunction

  // Small values force ties, values near the top force saturation.
  function automatic logic [AMT_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30)      return AMT_W'($urandom_range(3));
    else if (r < 40) return (r[0]) ? '1 : '0;
    else if (r < 60) return AMT_W'($urandom_range(16'hFFFF, 16'hFF00));
    else             return AMT_W'($urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Query an empty table: expect id zero with the empty flag.
  task automatic test_empty_query();
    send_req(MODE_QUERY, 10'h2AA, 16'h5555);
  endtask

  // Walk the field extremes and each corner of insert, increase and remove.
  // At these widths an id past the table, an over-wide priority and a
  // sequence wrap cannot be produced, so they are left to the shadow table.
  task automatic test_directed_corners();
    send_req(MODE_INSERT,   10'd0,    16'h0000);
    send_req(MODE_INSERT,   10'd1023, 16'hFFFF);
    send_req(MODE_QUERY,    10'd0,    16'h0000);  // 1023 leads
    send_req(MODE_INCREASE, 10'd1023, 16'h0001);  // saturate at the top
    send_req(MODE_INCREASE, 10'd0,    16'hFFFF);  // tie; earlier arrival wins
    send_req(MODE_QUERY,    10'd1023, 16'hFFFF);
    send_req(MODE_INCREASE, 10'd5,    16'h1234);  // absent id, drop
    send_req(MODE_REMOVE,   10'd7,    16'h0000);  // absent id, drop
    send_req(MODE_INSERT,   10'd0,    16'hFFFF);  // re-insert restamps arrival
    send_req(MODE_QUERY,    10'd0,    16'h0000);
    send_req(MODE_REMOVE,   10'd1023, 16'hFFFF);
    send_req(MODE_QUERY,    10'd0,    16'h0000);
    send_req(MODE_INSERT,   10'd512,  16'h8000);
    send_req(MODE_INSERT,   10'd511,  16'h7FFF);
    send_req(MODE_INCREASE, 10'd511,  16'h0001);  // tie with 512, 512 is older
    send_req(MODE_QUERY,    10'd0,    16'h0000);
    send_req(MODE_REMOVE,   10'd0,    16'h0000);
    send_req(MODE_REMOVE,   10'd512,  16'h0000);
    send_req(MODE_REMOVE,   10'd511,  16'h0000);
    send_req(MODE_QUERY,    10'd0,    16'h0000);  // empty again
  endtask

  // Random traffic over one id pool.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned pool,
                                     input bit with_stalls);
    logic [ID_W-1:0] mask;
    mask     = ID_W'($urandom());
    stall_en = with_stalls;
    repeat (n_items) send_req(pick_mode(), pick_id(pool, mask), pick_amount());
    stall_en = 1'b1;
  endtask

  // Fire a burst of queries, then pause the sender until all results are in.
  task automatic test_drain_pause();
    repeat (3) send_req(MODE_QUERY, ID_W'($urandom()), AMT_W'($urandom()));
    hold_until_drained();
    send_req(MODE_INSERT, ID_W'($urandom()), pick_amount());
    send_req(MODE_QUERY,  ID_W'($urandom()), AMT_W'($urandom()));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned waited;
    for (int unsigned i = 0; i < TB_ENTRIES; i++) shadow_present[i] = 1'b0;
    shadow_next_seq = '0;
    shadow_live     = '0;
    reqs_sent       = 0;
    queries_sent    = 0;
    results_checked = 0;
    err_count       = 0;
    stall_en        = 1'b1;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.mode     <= MODE_INSERT;
    req_if.entry_id <= '0;
    req_if.amount   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The clearing pass after reset is covered by waiting on ready.
    test_empty_query();
    test_directed_corners();
    test_random_traffic(200, 8, 1'b1);
    test_drain_pause();
    test_random_traffic(160, 32, 1'b0);
    test_random_traffic(215, 64, 1'b1);

    // Drain: wait for all predictions, bounded, then watch for strays.
    req_if.valid <= 1'b0;
    waited = 0;
    while (expected_best_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (QUERY_LAT + 16) @(posedge clk_i);
    if (expected_best_q.size() != 0) begin
      $display("%0t ERROR %0d results never arrived, oldest expected best_id=%0d is_empty=%0b",
               $time, expected_best_q.size(), expected_best_q[0].best_id,
               expected_best_q[0].is_empty);
      err_count++;
    end

    $display("summary: %0d request beats (%0d queries), %0d results checked",
             reqs_sent, queries_sent, results_checked);
    $display("summary: directed corners, empty, tie, saturation and random pools");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: bail out well past the slowest legal run.
  initial begin
    #40_000_000;
    $display("%0t ERROR timeout", $time);
    $display("status: fail");
    $finish;
  end

endmodule
